[sv/lmt_pkg.sv]
// Types, register map, mode codes and timing constants for the LCD mode timing block.
// No dependencies; the design, checker and testbench files import this package.
package lmt_pkg;

  // Item kinds
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // Display modes
  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_XFER   = 2'd3;

  // Register map
  localparam logic [15:0] ADDR_CONTROL  = 16'hFF40;
  localparam logic [15:0] ADDR_STATUS   = 16'hFF41;
  localparam logic [15:0] ADDR_SCROLL_Y = 16'hFF42;
  localparam logic [15:0] ADDR_SCROLL_X = 16'hFF43;
  localparam logic [15:0] ADDR_LINE     = 16'hFF44;
  localparam logic [15:0] ADDR_LINE_CMP = 16'hFF45;
  localparam logic [15:0] ADDR_BG_PAL   = 16'hFF47;
  localparam logic [15:0] ADDR_OBJ_PAL0 = 16'hFF48;
  localparam logic [15:0] ADDR_OBJ_PAL1 = 16'hFF49;
  localparam logic [15:0] ADDR_WIN_Y    = 16'hFF4A;
  localparam logic [15:0] ADDR_WIN_X    = 16'hFF4B;

  // Timing constants
  localparam int unsigned AccSpan    = 65536;
  localparam int unsigned HblankEnd  = 207;
  localparam int unsigned OamEnd     = 83;
  localparam int unsigned XferEnd    = 175;
  localparam int unsigned LineCycles = 465;
  localparam int unsigned FrameCyc   = 4560;

  localparam logic [15:0] HBLANK_END    = 16'(HblankEnd);
  localparam logic [15:0] OAM_END       = 16'(OamEnd);
  localparam logic [15:0] XFER_END      = 16'(XferEnd);
  localparam logic [9:0]  LINE_CYCLES   = 10'(LineCycles);
  localparam logic [13:0] FRAME_CYCLES  = 14'(FrameCyc);
  localparam logic [7:0]  VISIBLE_LINES = 8'd144;
  localparam logic [7:0]  LAST_LINE     = 8'd153;

  // Corrections applied when the 16-bit accumulator wraps: the residues
  // lose 2^16, written as a positive add plus a quotient borrow.
  localparam logic [9:0]  LINE_WRAP_R = 10'(LineCycles - (AccSpan % LineCycles));
  localparam logic [7:0]  LINE_WRAP_Q = 8'((AccSpan / LineCycles) + 1);
  localparam logic [13:0] FRAME_WRAP  = 14'(FrameCyc - (AccSpan % FrameCyc));
  localparam logic [8:0]  OAM_WRAP    = 9'((FrameCyc - (AccSpan % FrameCyc)) % OamEnd);
  // Residue mod 83 change when the frame residue drops one frame length
  localparam logic [8:0]  OAM_FRAME   = 9'(OamEnd - (FrameCyc % OamEnd));

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  tick_cycles;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
  } lmt_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [1:0] current_mode;
    logic [7:0] current_line;
    logic       line_transfer_done;
    logic       frame_done;
  } lmt_result_t;

  // Register file to sequencer
  typedef struct packed {
    logic display_on;
    logic line_clear;
  } lmt_ctrl_t;

  // Sequencer to register file: present line and mode
  typedef struct packed {
    logic [7:0] line;
    logic [1:0] mode;
  } lmt_status_t;

  // Sequencer result of one step
  typedef struct packed {
    logic [7:0] line;
    logic [1:0] mode;
    logic       xfer_done;
    logic       frame_done;
  } lmt_step_t;

  // x mod 83 for x below 415
  function automatic logic [6:0] mod83(input logic [8:0] x);
    logic [8:0] r;
    if (x >= 9'd332)      r = x - 9'd332;
    else if (x >= 9'd249) r = x - 9'd249;
    else if (x >= 9'd166) r = x - 9'd166;
    else if (x >= 9'd83)  r = x - 9'd83;
    else                  r = x;
    return r[6:0];
  endfunction

  // x mod 207 for x below 621
  function automatic logic [7:0] mod207(input logic [9:0] x);
    logic [9:0] r;
    if (x >= 10'd414)      r = x - 10'd414;
    else if (x >= 10'd207) r = x - 10'd207;
    else                   r = x;
    return r[7:0];
  endfunction

  // x mod 175 for x below 525
  function automatic logic [7:0] mod175(input logic [9:0] x);
    logic [9:0] r;
    if (x >= 10'd350)      r = x - 10'd350;
    else if (x >= 10'd175) r = x - 10'd175;
    else                   r = x;
    return r[7:0];
  endfunction

endpackage

[sv/lmt_ifs.sv]
// Handshake channel interfaces for the LCD mode timing block.
// Depends on nothing; payload fields follow the item and result layouts.
interface lmt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  tick_cycles;
  logic [15:0] bus_address;
  logic [7:0]  write_data;

  modport source (output valid, action, tick_cycles, bus_address, write_data,
                  input ready);
  modport sink   (input valid, action, tick_cycles, bus_address, write_data,
                  output ready);
endinterface

interface lmt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [1:0] current_mode;
  logic [7:0] current_line;
  logic       line_transfer_done;
  logic       frame_done;

  modport source (output valid, read_data, current_mode, current_line,
                  line_transfer_done, frame_done, input ready);
  modport sink   (input valid, read_data, current_mode, current_line,
                  line_transfer_done, frame_done, output ready);
endinterface

[sv/lmt_regfile.sv]
// Bus register file: control, status enables, scroll, compare, palettes, window.
// Depends on lmt_pkg; line and mode come from the sequencer.
module lmt_regfile
  import lmt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  lmt_item_t   item,
  input  lmt_status_t status,
  output lmt_ctrl_t   ctrl,
  output logic [7:0]  read_data
);

  logic [7:0] lcd_control;
  logic [3:0] status_enables;
  logic [7:0] scroll_y_reg;
  logic [7:0] scroll_x_reg;
  logic [7:0] line_compare;
  logic [7:0] bg_palette;
  logic [7:0] sprite_palette_a;
  logic [7:0] sprite_palette_b;
  logic [7:0] window_y_reg;
  logic [7:0] window_x_reg;
  logic       wr;
  logic [7:0] rd_value;

  assign wr = step && (item.action == ACT_WRITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      lcd_control      <= '0;
      status_enables   <= '0;
      scroll_y_reg     <= '0;
      scroll_x_reg     <= '0;
      line_compare     <= '0;
      bg_palette       <= '0;
      sprite_palette_a <= '0;
      sprite_palette_b <= '0;
      window_y_reg     <= '0;
      window_x_reg     <= '0;
    end else if (wr) begin
      unique case (item.bus_address)
        ADDR_CONTROL:  lcd_control      <= item.write_data;
        ADDR_STATUS:   status_enables   <= item.write_data[6:3];
        ADDR_SCROLL_Y: scroll_y_reg     <= item.write_data;
        ADDR_SCROLL_X: scroll_x_reg     <= item.write_data;
        ADDR_LINE_CMP: line_compare     <= item.write_data;
        ADDR_BG_PAL:   bg_palette       <= item.write_data;
        ADDR_OBJ_PAL0: sprite_palette_a <= item.write_data;
        ADDR_OBJ_PAL1: sprite_palette_b <= item.write_data;
        ADDR_WIN_Y:    window_y_reg     <= item.write_data;
        ADDR_WIN_X:    window_x_reg     <= item.write_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (item.bus_address)
      ADDR_CONTROL:  rd_value = lcd_control;
      ADDR_STATUS:   rd_value = {1'b0, status_enables,
                                 status.line == line_compare, status.mode};
      ADDR_SCROLL_Y: rd_value = scroll_y_reg;
      ADDR_SCROLL_X: rd_value = scroll_x_reg;
      ADDR_LINE:     rd_value = status.line;
      ADDR_LINE_CMP: rd_value = line_compare;
      ADDR_BG_PAL:   rd_value = bg_palette;
      ADDR_OBJ_PAL0: rd_value = sprite_palette_a;
      ADDR_OBJ_PAL1: rd_value = sprite_palette_b;
      ADDR_WIN_Y:    rd_value = window_y_reg;
      ADDR_WIN_X:    rd_value = window_x_reg;
      default:       rd_value = '0;
    endcase
  end

  assign read_data       = (item.action == ACT_READ) ? rd_value : '0;
  assign ctrl.display_on = lcd_control[7];
  assign ctrl.line_clear = (item.action == ACT_WRITE) && (item.bus_address == ADDR_LINE);

endmodule

[sv/lmt_timing.sv]
// Mode sequencer: cycle accumulator, line counter and display mode.
// Depends on lmt_pkg. Keeps running residues of the accumulator so that no
// divider is needed: by 465 (quotient and remainder), by 4560, and mod 83.
module lmt_timing
  import lmt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic        tick,
  input  logic [7:0]  cycles,
  input  lmt_ctrl_t   ctrl,
  output lmt_status_t status,
  output lmt_step_t   result
);

  // State
  logic [15:0] acc;
  logic [7:0]  q465;
  logic [8:0]  r465;
  logic [12:0] fr;     // acc mod 4560
  logic [6:0]  m83;    // fr mod 83 (equals acc mod 83 in OAM mode)
  logic [7:0]  line;
  logic [1:0]  mode;

  logic [15:0] acc_next;
  logic [7:0]  q465_next;
  logic [8:0]  r465_next;
  logic [12:0] fr_next;
  logic [6:0]  m83_next;
  logic [7:0]  line_next;
  logic [1:0]  mode_next;
  logic        xfer_done;
  logic        frame_done;

  // Incremental terms
  logic [16:0] sum;
  logic        wrap;
  logic [15:0] acc_s;
  logic [9:0]  t465;
  logic        ge465;
  logic [8:0]  r465_s;
  logic [7:0]  q465_s;
  logic [13:0] tfr;
  logic        sub_fr;
  logic [12:0] fr_s;
  logic [8:0]  t83;
  logic [6:0]  m83_s;
  logic [6:0]  oam_rem;
  logic [7:0]  line_inc;
  logic        vb_adv;

  // Reload from a value below 208
  logic        load_small;
  logic [7:0]  small_x;

  assign sum    = {1'b0, acc} + {9'b0, cycles};
  assign wrap   = sum[16];
  assign acc_s  = sum[15:0];

  assign t465   = {1'b0, r465} + {2'b0, cycles} + (wrap ? LINE_WRAP_R : 10'd0);
  assign ge465  = t465 >= LINE_CYCLES;
  assign r465_s = ge465 ? 9'(t465 - LINE_CYCLES) : t465[8:0];
  assign q465_s = q465 + {7'b0, ge465} - (wrap ? LINE_WRAP_Q : 8'd0);

  assign tfr    = {1'b0, fr} + {6'b0, cycles} + (wrap ? FRAME_WRAP : 14'd0);
  assign sub_fr = tfr >= FRAME_CYCLES;
  assign fr_s   = sub_fr ? 13'(tfr - FRAME_CYCLES) : tfr[12:0];

  assign t83    = {2'b0, m83} + {1'b0, cycles} + (wrap ? OAM_WRAP : 9'd0)
                  + (sub_fr ? OAM_FRAME : 9'd0);
  assign m83_s  = mod83(t83);

  // OAM mode: accumulator equals its frame residue, so no frame correction
  assign oam_rem  = mod83({2'b0, m83} + {1'b0, cycles});

  assign line_inc = line + 8'd1;
  assign vb_adv   = ({1'b0, q465_s} + 9'(VISIBLE_LINES)) > {1'b0, line};

  always_comb begin
    acc_next   = acc;
    q465_next  = q465;
    r465_next  = r465;
    fr_next    = fr;
    m83_next   = m83;
    line_next  = line;
    mode_next  = mode;
    xfer_done  = 1'b0;
    frame_done = 1'b0;
    load_small = 1'b0;
    small_x    = '0;
    if (tick) begin
      if (!ctrl.display_on) begin
        line_next  = '0;
        load_small = 1'b1;
      end else begin
        unique case (mode)
          MODE_HBLANK: begin
            load_small = 1'b1;
            if (acc_s > HBLANK_END) begin
              line_next = line_inc;
              mode_next = (line_inc == VISIBLE_LINES) ? MODE_VBLANK : MODE_OAM;
              small_x   = mod207(acc_s[9:0]);
            end else begin
              small_x   = acc_s[7:0];
            end
          end
          MODE_VBLANK: begin
            acc_next  = acc_s;
            q465_next = q465_s;
            r465_next = r465_s;
            fr_next   = fr_s;
            m83_next  = m83_s;
            if (vb_adv) begin
              line_next = line_inc;
              if (line_inc > LAST_LINE) begin
                // Wrap the frame: the accumulator keeps its frame residue
                line_next  = '0;
                mode_next  = MODE_OAM;
                acc_next   = {3'b0, fr_s};
                frame_done = 1'b1;
              end
            end
          end
          MODE_OAM: begin
            load_small = 1'b1;
            if (acc_s > OAM_END) begin
              mode_next = MODE_XFER;
              small_x   = {1'b0, oam_rem};
            end else begin
              small_x   = acc_s[7:0];
            end
          end
          MODE_XFER: begin
            load_small = 1'b1;
            if (acc_s > XFER_END) begin
              mode_next = MODE_HBLANK;
              xfer_done = 1'b1;
              small_x   = mod175(acc_s[9:0]);
            end else begin
              small_x   = acc_s[7:0];
            end
          end
          default: ;
        endcase
      end
      if (load_small) begin
        acc_next  = {8'b0, small_x};
        q465_next = '0;
        r465_next = {1'b0, small_x};
        fr_next   = {5'b0, small_x};
        m83_next  = mod83({1'b0, small_x});
      end
    end else if (ctrl.line_clear) begin
      line_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      q465 <= '0;
      r465 <= '0;
      fr   <= '0;
      m83  <= '0;
      line <= '0;
      mode <= MODE_OAM;
    end else if (step) begin
      acc  <= acc_next;
      q465 <= q465_next;
      r465 <= r465_next;
      fr   <= fr_next;
      m83  <= m83_next;
      line <= line_next;
      mode <= mode_next;
    end
  end

  assign status.line       = line;
  assign status.mode       = mode;
  assign result.line       = line_next;
  assign result.mode       = mode_next;
  assign result.xfer_done  = xfer_done;
  assign result.frame_done = frame_done;

endmodule

[sv/lcd_mode_timing_registers.sv]
// Top level of the LCD mode timing and register block.
// Depends on lmt_pkg, lmt_ifs, lmt_regfile and lmt_timing.
//
// Usage:
//   in_ch carries one beat per item: a tick (action 0) that adds tick_cycles
//   to the cycle accumulator and steps the OAM / transfer / H-blank / V-blank
//   sequence, a register write (action 1) or a register read (action 2) at
//   bus_address 0xFF40..0xFF4B. Action 3 is a no-op that still gives a beat.
//   out_ch returns exactly one beat per input beat, in order: read_data (zero
//   unless a read hits a known register), mode and line after the step, and
//   the end-of-transfer and end-of-frame pulses.
//   Each item passes the input register, then the step logic into the result
//   register, which drives out_ch.valid. Throughput: one item per cycle while
//   out_ch accepts; the state update of one item completes in the cycle it
//   leaves the input register, so the next item follows directly.
//   Stall: when out_ch.ready is low the result register holds its beat, the
//   input register still fills once, and in_ch.ready drops only while both
//   are full.
//   Reset (rst, synchronous): all bus registers, line and accumulator clear,
//   mode goes to OAM, both pipeline stages empty.
module lcd_mode_timing_registers
  import lmt_pkg::*;
(
  input logic  clk,
  input logic  rst,
  lmt_in_if.sink    in_ch,
  lmt_out_if.source out_ch
);

  // Input register
  logic        s1_valid;
  lmt_item_t   s1_item;

  // Result register
  logic        o_valid;
  lmt_result_t o_res;

  logic        advance;
  logic        step;

  lmt_ctrl_t   ctrl;
  lmt_status_t status;
  lmt_step_t   seq;
  logic [7:0]  rd_data;

  // Move the input stage forward whenever the result slot is free or drains
  assign advance     = !o_valid || out_ch.ready;
  assign step        = s1_valid && advance;
  assign in_ch.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  // Payload: capture on accept, no reset needed
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item.action      <= in_ch.action;
      s1_item.tick_cycles <= in_ch.tick_cycles;
      s1_item.bus_address <= in_ch.bus_address;
      s1_item.write_data  <= in_ch.write_data;
    end
  end

  lmt_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (s1_item),
    .status    (status),
    .ctrl      (ctrl),
    .read_data (rd_data)
  );

  lmt_timing u_timing (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .tick   (s1_item.action == ACT_TICK),
    .cycles (s1_item.tick_cycles),
    .ctrl   (ctrl),
    .status (status),
    .result (seq)
  );

  // Result register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      o_res.read_data          <= rd_data;
      o_res.current_mode       <= seq.mode;
      o_res.current_line       <= seq.line;
      o_res.line_transfer_done <= seq.xfer_done;
      o_res.frame_done         <= seq.frame_done;
    end
  end

  assign out_ch.valid              = o_valid;
  assign out_ch.read_data          = o_res.read_data;
  assign out_ch.current_mode       = o_res.current_mode;
  assign out_ch.current_line       = o_res.current_line;
  assign out_ch.line_transfer_done = o_res.line_transfer_done;
  assign out_ch.frame_done         = o_res.frame_done;

endmodule

[sv/lmt_checker.sv]
// Port-level checks for the LCD mode timing block, attached by bind.
// Depends on lmt_pkg and the top level lcd_mode_timing_registers.
module lmt_checker
  import lmt_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] read_data,
  input logic [1:0] current_mode,
  input logic [7:0] current_line,
  input logic       line_transfer_done,
  input logic       frame_done
);

  // A frame wrap lands on line 0 in OAM mode
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> current_mode == MODE_OAM && current_line == 8'd0)
    else $error("frame_done without OAM mode on line 0");

  // End of transfer always hands over to H-blank
  a_xfer_hblank: assert property (@(posedge clk) disable iff (rst)
    out_valid && line_transfer_done |-> current_mode == MODE_HBLANK)
    else $error("line_transfer_done outside H-blank");

  // One step ends at most one phase
  a_one_pulse: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(line_transfer_done && frame_done))
    else $error("both pulses in one beat");

  // Hold a stalled result beat
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data)
      && $stable(current_mode) && $stable(current_line))
    else $error("stalled result beat changed");

endmodule

bind lcd_mode_timing_registers lmt_checker u_lmt_checker (
  .clk                (clk),
  .rst                (rst),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .read_data          (out_ch.read_data),
  .current_mode       (out_ch.current_mode),
  .current_line       (out_ch.current_line),
  .line_transfer_done (out_ch.line_transfer_done),
  .frame_done         (out_ch.frame_done)
);

[dv/tb_lcd_mode_timing_registers.sv]
// Self-checking testbench for lcd_mode_timing_registers: the mode and line sequencer
// and the bus register file. Depends on lmt_pkg and the lmt_in_if / lmt_out_if channels.
// Runs directed register and timing beats, then random traffic under four idling phases.
module tb_lcd_mode_timing_registers;
  import lmt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Action 3 does nothing in the block but still returns a beat.
  localparam logic [1:0]  ACT_NOP       = 2'd3;
  // Hole in the register map: writes are dropped, reads return zero.
  localparam logic [15:0] ADDR_UNMAPPED = 16'hFF46;

  localparam int          RANDOM_PER_PHASE = 456;
  localparam int          HOLD_CYCLES      = 150;
  localparam int          SETTLE_CYCLES    = 8;
  localparam int unsigned CYCLE_LIMIT      = 400000;

  logic clk;
  logic rst;

  lmt_in_if  in_ch ();
  lmt_out_if out_ch ();

  lcd_mode_timing_registers DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Clock: 10 ns period, low first so the first falling edge comes at 10 ns.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the display state, advanced once per accepted input beat.
  // ---------------------------------------------------------------------------
  logic [7:0]  lcd_ctrl;
  logic [3:0]  stat_enables;
  logic [7:0]  scy, scx;
  logic [7:0]  line;
  logic [7:0]  lyc;
  logic [7:0]  bgp, obp0, obp1;
  logic [7:0]  wy, wx;
  logic [1:0]  mode;
  logic [15:0] accum;

  // Items waiting to be offered, and the results the block still owes us.
  lmt_item_t   bus_items_todo[$];
  lmt_result_t lcd_results_due[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic        in_taken;
  logic        hold_go;
  logic        rx_hold;

  int unsigned cycle_count;
  int          error_count;
  int          beats_checked;
  int          line_ends_seen;
  int          frames_seen;
  int          status_reads;

  // Apply one item to the shadow state and return the beat the block must give.
  function automatic lmt_result_t step_lcd(lmt_item_t it);
    lmt_result_t r;
    logic [15:0] acc;
    r = '0;
    case (it.action)
      ACT_TICK: begin
        if (!lcd_ctrl[7]) begin
          // display off: clear counters, keep the mode, no pulses
          accum = '0;
          line  = '0;
        end else begin
          acc = accum + 16'(it.tick_cycles);
          case (mode)
            MODE_HBLANK: begin
              if (acc > HBLANK_END) begin
                line = line + 8'd1;
                mode = (line == VISIBLE_LINES) ? MODE_VBLANK : MODE_OAM;
                acc  = acc % HBLANK_END;
              end
            end
            MODE_VBLANK: begin
              // step one line whenever the accumulated time is ahead of it
              if (acc / LineCycles + VISIBLE_LINES > line) begin
                line = line + 8'd1;
                if (line > LAST_LINE) begin
                  mode         = MODE_OAM;
                  acc          = acc % 16'(FrameCyc);
                  line         = '0;
                  r.frame_done = 1'b1;
                end
              end
            end
            MODE_OAM: begin
              if (acc > OAM_END) begin
                mode = MODE_XFER;
                acc  = acc % OAM_END;
              end
            end
            default: begin
              if (acc > XFER_END) begin
                mode                 = MODE_HBLANK;
                acc                  = acc % XFER_END;
                r.line_transfer_done = 1'b1;
              end
            end
          endcase
          accum = acc;
        end
      end
      ACT_WRITE: begin
        case (it.bus_address)
          ADDR_CONTROL:  lcd_ctrl     = it.write_data;
          ADDR_STATUS:   stat_enables = it.write_data[6:3];
          ADDR_SCROLL_Y: scy          = it.write_data;
          ADDR_SCROLL_X: scx          = it.write_data;
          ADDR_LINE:     line         = '0;
          ADDR_LINE_CMP: lyc          = it.write_data;
          ADDR_BG_PAL:   bgp          = it.write_data;
          ADDR_OBJ_PAL0: obp0         = it.write_data;
          ADDR_OBJ_PAL1: obp1         = it.write_data;
          ADDR_WIN_Y:    wy           = it.write_data;
          ADDR_WIN_X:    wx           = it.write_data;
          default: ;
        endcase
      end
      ACT_READ: begin
        case (it.bus_address)
          ADDR_CONTROL:  r.read_data = lcd_ctrl;
          ADDR_STATUS:   r.read_data = {1'b0, stat_enables, line == lyc, mode};
          ADDR_SCROLL_Y: r.read_data = scy;
          ADDR_SCROLL_X: r.read_data = scx;
          ADDR_LINE:     r.read_data = line;
          ADDR_LINE_CMP: r.read_data = lyc;
          ADDR_BG_PAL:   r.read_data = bgp;
          ADDR_OBJ_PAL0: r.read_data = obp0;
          ADDR_OBJ_PAL1: r.read_data = obp1;
          ADDR_WIN_Y:    r.read_data = wy;
          ADDR_WIN_X:    r.read_data = wx;
          default:       r.read_data = '0;
        endcase
      end
      default: ;
    endcase
    r.current_mode = mode;
    r.current_line = line;
    return r;
  endfunction

  function automatic lmt_item_t bus_item(logic [1:0] act, logic [7:0] cyc,
                                         logic [15:0] addr, logic [7:0] data);
    lmt_item_t it;
    it.action      = act;
    it.tick_cycles = cyc;
    it.bus_address = addr;
    it.write_data  = data;
    return it;
  endfunction

  function automatic logic [15:0] mapped_addr(int unsigned k);
    case (k)
      0:       return ADDR_CONTROL;
      1:       return ADDR_STATUS;
      2:       return ADDR_SCROLL_Y;
      3:       return ADDR_SCROLL_X;
      4:       return ADDR_LINE;
      5:       return ADDR_LINE_CMP;
      6:       return ADDR_BG_PAL;
      7:       return ADDR_OBJ_PAL0;
      8:       return ADDR_OBJ_PAL1;
      9:       return ADDR_WIN_Y;
      default: return ADDR_WIN_X;
    endcase
  endfunction

  // Random traffic, mostly ticks so the sequencer walks through whole frames.
  // Control writes are rare and mostly keep the display on; line writes are
  // rare too, otherwise V-blank would hardly ever be reached.
  function automatic lmt_item_t random_item();
    lmt_item_t   it;
    int unsigned pick;
    int unsigned sel;
    it   = bus_item(2'($urandom_range(3)), 8'($urandom), 16'($urandom), 8'($urandom));
    pick = $urandom_range(99);
    if (pick < 80) begin
      it.action = ACT_TICK;
      sel = $urandom_range(9);
      if (sel < 7)      it.tick_cycles = 8'($urandom_range(255, 180));
      else if (sel < 9) it.tick_cycles = 8'($urandom_range(255));
      else              it.tick_cycles = 8'($urandom_range(3));
    end else if (pick < 88) begin
      it.action      = ACT_READ;
      it.bus_address = ($urandom_range(2) == 0) ? ADDR_STATUS : mapped_addr($urandom_range(10));
    end else if (pick < 95) begin
      it.action = ACT_WRITE;
      sel = $urandom_range(19);
      if (sel == 0) begin
        it.bus_address = ADDR_CONTROL;
        if ($urandom_range(3) != 0) it.write_data[7] = 1'b1;
      end else if (sel == 1) begin
        it.bus_address = ADDR_LINE;
      end else begin
        it.bus_address = mapped_addr(sel % 11);
        if (it.bus_address == ADDR_CONTROL || it.bus_address == ADDR_LINE)
          it.bus_address = ADDR_LINE_CMP;
        // aim line compare at reachable lines so the match bit toggles
        if (it.bus_address == ADDR_LINE_CMP && $urandom_range(1) == 0)
          it.write_data = 8'($urandom_range(154));
      end
    end else if (pick < 98) begin
      it.action = ($urandom_range(1) == 0) ? ACT_WRITE : ACT_READ;
    end else begin
      it.action = ACT_NOP;
    end
    return it;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    error_count++;
    $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  // Block until every queued item has gone in and every owed beat came back.
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (bus_items_todo.size() != 0 || in_ch.valid || lcd_results_due.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: change on the falling edge, hold a beat until it is taken.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : bus_driver
    lmt_item_t nxt;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (bus_items_todo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = bus_items_todo.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.action      <= nxt.action;
        in_ch.tick_cycles <= nxt.tick_cycles;
        in_ch.bus_address <= nxt.bus_address;
        in_ch.write_data  <= nxt.write_data;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result ready: random stalls, plus the long hold-off while rx_hold is up.
  always @(negedge clk) begin : result_ready
    if (rst) out_ch.ready <= 1'b0;
    else     out_ch.ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // Long receiver hold-off, counted here so the sender keeps offering beats
  // and the two pipeline stages fill up and push back on the input.
  initial begin : rx_hold_off
    rx_hold = 1'b0;
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Rising edge: record accepted items, advance the shadow state, and compare
  // each returned beat with the oldest owed result.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : beat_monitor
    lmt_item_t   got_item;
    lmt_result_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        got_item = bus_item(in_ch.action, in_ch.tick_cycles, in_ch.bus_address,
                            in_ch.write_data);
        lcd_results_due.push_back(step_lcd(got_item));
        if (got_item.action == ACT_READ && got_item.bus_address == ADDR_STATUS)
          status_reads++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (lcd_results_due.size() == 0) begin
          report_mismatch("beat with nothing owed", 1, 0);
        end else begin
          want = lcd_results_due.pop_front();
          beats_checked++;
          if (want.line_transfer_done) line_ends_seen++;
          if (want.frame_done)         frames_seen++;
          if (out_ch.read_data !== want.read_data)
            report_mismatch("read_data", out_ch.read_data, want.read_data);
          if (out_ch.current_mode !== want.current_mode)
            report_mismatch("current_mode", out_ch.current_mode, want.current_mode);
          if (out_ch.current_line !== want.current_line)
            report_mismatch("current_line", out_ch.current_line, want.current_line);
          if (out_ch.line_transfer_done !== want.line_transfer_done)
            report_mismatch("line_transfer_done", out_ch.line_transfer_done,
                            want.line_transfer_done);
          if (out_ch.frame_done !== want.frame_done)
            report_mismatch("frame_done", out_ch.frame_done, want.frame_done);
        end
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still owed", cycle_count,
               lcd_results_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed beats, then four random phases.
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    // drive every input to a known value from time zero
    clk               = 1'b0;
    rst               = 1'b1;
    in_ch.valid       = 1'b0;
    in_ch.action      = ACT_NOP;
    in_ch.tick_cycles = '0;
    in_ch.bus_address = '0;
    in_ch.write_data  = '0;
    out_ch.ready      = 1'b0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    hold_go           = 1'b0;
    cycle_count       = 0;
    error_count       = 0;
    beats_checked     = 0;
    line_ends_seen    = 0;
    frames_seen       = 0;
    status_reads      = 0;

    // shadow state after reset: everything clear, mode OAM
    lcd_ctrl = '0; stat_enables = '0; scy = '0; scx = '0; line = '0; lyc = '0;
    bgp = '0; obp0 = '0; obp1 = '0; wy = '0; wx = '0;
    mode  = MODE_OAM;
    accum = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(posedge clk);
    #1;

    // Directed beats, no idling.
    // Status on reset shows OAM mode and a line compare match at line zero.
    bus_items_todo.push_back(bus_item(ACT_READ,  8'h00, ADDR_STATUS,   8'h00));
    // Tick with the display off: counters stay clear, no pulses.
    bus_items_todo.push_back(bus_item(ACT_TICK,  8'hFF, ADDR_CONTROL,  8'hFF));
    bus_items_todo.push_back(bus_item(ACT_WRITE, 8'h00, ADDR_CONTROL,  8'hFF));
    // Status write keeps only the four enable bits.
    bus_items_todo.push_back(bus_item(ACT_WRITE, 8'h00, ADDR_STATUS,   8'hFF));
    bus_items_todo.push_back(bus_item(ACT_READ,  8'h00, ADDR_STATUS,   8'h00));
    bus_items_todo.push_back(bus_item(ACT_WRITE, 8'h00, ADDR_SCROLL_Y, 8'hA5));
    bus_items_todo.push_back(bus_item(ACT_WRITE, 8'h00, ADDR_SCROLL_X, 8'h5A));
    bus_items_todo.push_back(bus_item(ACT_WRITE, 8'h00, ADDR_LINE_CMP, 8'h01));
    bus_items_todo.push_back(bus_item(ACT_WRITE, 8'h00, ADDR_BG_PAL,   8'hFF));
    bus_items_todo.push_back(bus_item(ACT_WRITE, 8'h00, ADDR_OBJ_PAL0, 8'h00));
    bus_items_todo.push_back(bus_item(ACT_WRITE, 8'h00, ADDR_OBJ_PAL1, 8'h3C));
    bus_items_todo.push_back(bus_item(ACT_WRITE, 8'h00, ADDR_WIN_Y,    8'hC3));
    bus_items_todo.push_back(bus_item(ACT_WRITE, 8'h00, ADDR_WIN_X,    8'h7E));
    // Unmapped addresses: write dropped, read gives zero.
    bus_items_todo.push_back(bus_item(ACT_WRITE, 8'h00, ADDR_UNMAPPED, 8'hFF));
    bus_items_todo.push_back(bus_item(ACT_READ,  8'h00, ADDR_UNMAPPED, 8'h00));
    bus_items_todo.push_back(bus_item(ACT_READ,  8'hFF, 16'hFFFF,      8'hFF));
    // No-op action with a live-looking payload changes nothing.
    bus_items_todo.push_back(bus_item(ACT_NOP,   8'hFF, ADDR_CONTROL,  8'h00));
    // Walk OAM -> transfer -> H-blank -> OAM of line 1; thresholds are strict.
    bus_items_todo.push_back(bus_item(ACT_TICK,  8'h00, 16'h0000,      8'h00));
    bus_items_todo.push_back(bus_item(ACT_TICK,  8'd84, 16'h0000,      8'h00));
    bus_items_todo.push_back(bus_item(ACT_TICK,  8'hFF, 16'h0000,      8'h00));
    bus_items_todo.push_back(bus_item(ACT_TICK,  8'hFF, 16'h0000,      8'h00));
    // Line 1 now equals the compare value.
    bus_items_todo.push_back(bus_item(ACT_READ,  8'h00, ADDR_STATUS,   8'h00));
    // Any line write clears the line.
    bus_items_todo.push_back(bus_item(ACT_WRITE, 8'h00, ADDR_LINE,     8'h55));
    bus_items_todo.push_back(bus_item(ACT_READ,  8'h00, ADDR_LINE,     8'h00));
    bus_items_todo.push_back(bus_item(ACT_WRITE, 8'h00, ADDR_STATUS,   8'h00));
    wait_drained();

    // Random phases: no idling (with the long hold-off), sender mostly idle,
    // receiver mostly stalled, both lightly idle. Drain between phases so the
    // sender also pauses with nothing owed.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      repeat (RANDOM_PER_PHASE) bus_items_todo.push_back(random_item());
      if (ph == 0) hold_go = 1'b1;
      wait_drained();
    end

    // Let the pipeline settle; a stray beat here shows up as a mismatch.
    repeat (SETTLE_CYCLES) @(posedge clk);
    #1;
    if (lcd_results_due.size() != 0)
      report_mismatch("beats never returned", lcd_results_due.size(), 0);

    $display("checked %0d beats (%0d status reads) over four idling phases,",
             beats_checked, status_reads);
    $display("with %0d line transfer ends and %0d frame wraps; %0d mismatches",
             line_ends_seen, frames_seen, error_count);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
